FILE: src/rwbc_pkg.sv
// ----------------------------------------------------------------------------
// rwbc_pkg
// Shared types and constants of the register write burst coalescer.
// ----------------------------------------------------------------------------
package rwbc_pkg;

  localparam int ADDR_W    = 16;
  localparam int BYTE_W    = 8;
  localparam int SLOT_W    = 25;
  localparam int SLOT_EN   = 24;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_WAIT  = 2'd1,
    CMD_END   = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_WAIT = 2'd1,
    KIND_DONE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FLUSH,
    ST_TAIL
  } state_t;

  // what follows the burst flush
  typedef enum logic [1:0] {
    AFT_NONE,
    AFT_APPEND,
    AFT_TAIL
  } after_t;

  typedef struct packed {
    logic append_in;
    logic latch_pend;
    logic flush_start;
    logic emit_byte;
    logic byte_last_ok;
    logic append_pend;
    logic emit_tail;
  } ctrl_t;

  typedef struct packed {
    logic fill_zero;
    logic consec;
    logic full_next;
    logic flush_final;
    logic out_free;
  } status_t;

endpackage

FILE: src/register_write_burst_coalescer.sv
// ----------------------------------------------------------------------------
// register_write_burst_coalescer
// Merges register-table writes to consecutive addresses into byte bursts and
// passes wait and end entries on after flushing the open burst.
// ----------------------------------------------------------------------------
// A write that extends the open burst without filling it gives no transfer. A
// flush sends one byte per cycle from the output register while the output is
// not stalled (burst data memory read one entry a cycle), then any wait or done
// result; no entry is taken while a flush or that result is in progress. The
// sequencer first changes state, then the first result is registered.
// rst is synchronous: buffer empty, override slots disabled, output empty.
module register_write_burst_coalescer
  import rwbc_pkg::*;
#(
  parameter int BURST_BYTES    = 32,
  parameter int OVERRIDE_SLOTS = 6
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SLOT_W-1:0]    cfg_data,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [23:0]          s_tdata,   // reg_addr[15:0], reg_value[23:16]
  input  logic [1:0]           s_tuser,   // command[1:0]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [7:0]           m_tdata,   // out_data[7:0]
  output logic [2:0]           m_tuser,   // out_kind[1:0], end_of_burst[2]
  output logic                 m_tlast
);

  ctrl_t   cmd;
  status_t st;
  kind_t   o_kind;
  logic    o_eob;
  cmd_t    in_cmd;

  assign in_cmd = cmd_t'(s_tuser);

  rwbc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_cmd   (in_cmd),
    .st       (st),
    .cmd      (cmd)
  );

  rwbc_dp #(
    .BURST_BYTES    (BURST_BYTES),
    .OVERRIDE_SLOTS (OVERRIDE_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_cmd    (in_cmd),
    .in_addr   (s_tdata[15:0]),
    .in_val    (s_tdata[23:16]),
    .cmd       (cmd),
    .st        (st),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_kind  (o_kind),
    .out_data  (m_tdata),
    .out_eob   (o_eob),
    .out_last  (m_tlast)
  );

  assign m_tuser = {o_eob, o_kind};

endmodule

FILE: src/rwbc_ctrl.sv
// ----------------------------------------------------------------------------
// rwbc_ctrl
// Sequencer: classifies each accepted entry and steps the flush and the
// trailing wait/done result.
// ----------------------------------------------------------------------------
module rwbc_ctrl
  import rwbc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  cmd_t    in_cmd,
  input  status_t st,
  output ctrl_t   cmd
);

  state_t state, state_next;
  after_t after, after_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      after <= AFT_NONE;
    end else begin
      state <= state_next;
      after <= after_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_cmd)
            CMD_WRITE: begin
              if ((!st.fill_zero && !st.consec) || st.full_next) begin
                state_next = ST_FLUSH;
              end
            end
            CMD_WAIT, CMD_END: begin
              state_next = st.fill_zero ? ST_TAIL : ST_FLUSH;
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_FLUSH: begin
        if (st.out_free && st.flush_final) begin
          state_next = (after == AFT_TAIL) ? ST_TAIL : ST_IDLE;
        end
      end
      ST_TAIL: begin
        if (st.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    after_next = after;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_cmd)
            CMD_WRITE: begin
              if (!st.fill_zero && !st.consec) begin
                cmd.latch_pend  = 1'b1;
                cmd.flush_start = 1'b1;
                after_next      = AFT_APPEND;
              end else begin
                cmd.append_in = 1'b1;
                if (st.full_next) begin
                  cmd.flush_start = 1'b1;
                  after_next      = AFT_NONE;
                end
              end
            end
            CMD_WAIT, CMD_END: begin
              cmd.latch_pend = 1'b1;
              if (!st.fill_zero) begin
                cmd.flush_start = 1'b1;
                after_next      = AFT_TAIL;
              end
            end
            default: cmd = '0;
          endcase
        end
      end
      ST_FLUSH: begin
        if (st.out_free) begin
          cmd.emit_byte    = 1'b1;
          cmd.byte_last_ok = (after != AFT_TAIL);
          cmd.append_pend  = st.flush_final && (after == AFT_APPEND);
        end
      end
      ST_TAIL: begin
        cmd.emit_tail = st.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

FILE: src/rwbc_dp.sv
// ----------------------------------------------------------------------------
// rwbc_dp
// Datapath: override slots, burst data memory, fill count, flush pointer
// and the output register.
// ----------------------------------------------------------------------------
module rwbc_dp
  import rwbc_pkg::*;
#(
  parameter int BURST_BYTES    = 32,
  parameter int OVERRIDE_SLOTS = 6
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SLOT_W-1:0]    cfg_data,
  input  cmd_t                 in_cmd,
  input  logic [ADDR_W-1:0]    in_addr,
  input  logic [BYTE_W-1:0]    in_val,
  input  ctrl_t                cmd,
  output status_t              st,
  output logic                 out_valid,
  input  logic                 out_ready,
  output kind_t                out_kind,
  output logic [BYTE_W-1:0]    out_data,
  output logic                 out_eob,
  output logic                 out_last
);

  localparam int DEPTH = BURST_BYTES - 2;
  localparam int AW    = $clog2(DEPTH);
  localparam int FW    = $clog2(BURST_BYTES + 1);

  logic [SLOT_W-1:0] slot [OVERRIDE_SLOTS];
  logic [BYTE_W-1:0] mem  [DEPTH];
  logic [BYTE_W-1:0] rdata;

  logic [FW-1:0]     fill, fill_next;
  logic [FW-1:0]     pos, pos_next;
  logic [ADDR_W-1:0] prev_addr, start_addr;
  logic [ADDR_W-1:0] pend_addr;
  logic [BYTE_W-1:0] pend_val;
  kind_t             pend_kind;

  logic [BYTE_W-1:0] ov_val;
  logic              we;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [BYTE_W-1:0] wr_data;
  logic [FW-1:0]     fill_m2, pos_m2;
  logic [BYTE_W-1:0] byte_sel;

  // override: lowest enabled matching slot wins
  always_comb begin
    ov_val = in_val;
    for (int k = OVERRIDE_SLOTS - 1; k >= 0; k--) begin
      if (slot[k][SLOT_EN] && slot[k][SLOT_EN-1:BYTE_W] == in_addr) begin
        ov_val = slot[k][BYTE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < OVERRIDE_SLOTS; k++) begin
        slot[k] <= '0;
      end
    end else if (cfg_we) begin
      for (int k = 0; k < OVERRIDE_SLOTS; k++) begin
        if (cfg_index == CFG_IDX_W'(k)) begin
          slot[k] <= cfg_data;
        end
      end
    end
  end

  assign st.fill_zero   = (fill == '0);
  assign st.consec      = ({1'b0, in_addr} == ({1'b0, prev_addr} + (ADDR_W+1)'(1)));
  assign st.full_next   = (fill == FW'(BURST_BYTES - 1));
  assign st.flush_final = (pos == fill - FW'(1));
  assign st.out_free    = !out_valid || out_ready;

  assign fill_m2 = fill - FW'(2);
  assign pos_m2  = pos_next - FW'(2);

  always_comb begin
    we      = cmd.append_in || cmd.append_pend;
    wr_data = cmd.append_pend ? pend_val : ov_val;
    wr_addr = (cmd.append_pend || fill == '0) ? '0 : fill_m2[AW-1:0];
    rd_addr = (pos_next < FW'(2)) ? '0 : pos_m2[AW-1:0];
  end

  always_comb begin
    if (cmd.flush_start) begin
      pos_next = '0;
    end else if (cmd.emit_byte) begin
      pos_next = pos + FW'(1);
    end else begin
      pos_next = pos;
    end
  end

  always_comb begin
    fill_next = fill;
    if (cmd.append_in) begin
      fill_next = (fill == '0) ? FW'(3) : fill + FW'(1);
    end else if (cmd.append_pend) begin
      fill_next = FW'(3);
    end else if (cmd.emit_byte && st.flush_final) begin
      fill_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      pos       <= '0;
      prev_addr <= '0;
    end else begin
      fill <= fill_next;
      pos  <= pos_next;
      if (cmd.append_in) begin
        prev_addr <= in_addr;
      end else if (cmd.append_pend) begin
        prev_addr <= pend_addr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.append_in && fill == '0) begin
      start_addr <= in_addr;
    end else if (cmd.append_pend) begin
      start_addr <= pend_addr;
    end
    if (cmd.latch_pend) begin
      pend_addr <= in_addr;
      case (in_cmd)
        CMD_WRITE: pend_val <= ov_val;
        CMD_WAIT:  pend_val <= in_val;
        default:   pend_val <= '0;
      endcase
      pend_kind <= (in_cmd == CMD_WAIT) ? KIND_WAIT : KIND_DONE;
    end
  end

  // burst header: address high byte, then low byte, then data
  always_comb begin
    if (pos == '0) begin
      byte_sel = start_addr[ADDR_W-1:BYTE_W];
    end else if (pos == FW'(1)) begin
      byte_sel = start_addr[BYTE_W-1:0];
    end else begin
      byte_sel = rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_byte || cmd.emit_tail) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_byte) begin
      out_kind <= KIND_BYTE;
      out_data <= byte_sel;
      out_eob  <= st.flush_final;
      out_last <= st.flush_final && cmd.byte_last_ok;
    end else if (cmd.emit_tail) begin
      out_kind <= pend_kind;
      out_data <= pend_val;
      out_eob  <= 1'b0;
      out_last <= 1'b1;
    end
  end

endmodule

FILE: src/rwbc_checker.sv
// ----------------------------------------------------------------------------
// rwbc_checker
// Port-level checks of the burst coalescer output stream.
// ----------------------------------------------------------------------------
module rwbc_checker
  import rwbc_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic [2:0] m_tuser,
  input logic       m_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("output transfer changed while stalled");

  a_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser[1:0] == KIND_BYTE || m_tuser[1:0] == KIND_WAIT
      || m_tuser[1:0] == KIND_DONE)
    else $error("bad result kind");

  a_tail: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1:0] != KIND_BYTE |-> m_tlast && !m_tuser[2])
    else $error("wait/done result without tlast or with end of burst");

  a_last_byte: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast && m_tuser[1:0] == KIND_BYTE |-> m_tuser[2])
    else $error("last byte result not at end of burst");

  a_done_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1:0] == KIND_DONE |-> m_tdata == 8'd0)
    else $error("done result carries data");

endmodule

bind register_write_burst_coalescer rwbc_checker u_rwbc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
